// ===== hw/rtl/lru_tag_cache_top_defines.svh =====
// Assertion macros shared by the LRU tag cache RTL.
// No dependencies; expects clk and arst_n in the including scope.
`ifndef LRU_TAG_CACHE_TOP_DEFINES_SVH
`define LRU_TAG_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define LRUTC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define LRUTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lrutc_pkg.sv =====
// Shared constants and the result record of the LRU tag cache.
// No dependencies.
package lrutc_pkg;

	localparam int LRUTC_CAPACITY = 8;
	localparam int LRUTC_KEY_BITS = 32;

	localparam int LRUTC_KEY_W    = 32;
	localparam int LRUTC_SLOT_W   = 3;
	localparam int LRUTC_OCC_W    = 4;

	localparam int LRUTC_IN_DATA_W  = 32;
	localparam int LRUTC_OUT_DATA_W = 48;

	typedef struct packed {
		logic                    hit;
		logic [LRUTC_SLOT_W-1:0] slot;
		logic                    evicted;
		logic [LRUTC_KEY_W-1:0]  evicted_key;
		logic                    inserted;
		logic [LRUTC_OCC_W-1:0]  occupancy;
	} lrutc_result_t;

endpackage

// ===== hw/rtl/lru_tag_cache_top.sv =====
// LRU tag cache top level. Items pass the input register, then the result register (m_tvalid).
// Throughput: one item per cycle; lrutc_store compares and ages all entries combinationally
// between input register and result register. Only a result that m_tready holds back
// stalls the input.
// Reset (arst_n low, asynchronous) clears valid bits, ages and fill count at once; keys stay.
// Depends on lrutc_pkg, lrutc_store and lru_tag_cache_top_defines.svh.
module lru_tag_cache_top #(
	parameter int CAPACITY = lrutc_pkg::LRUTC_CAPACITY,
	parameter int KEY_BITS = lrutc_pkg::LRUTC_KEY_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// request stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [lrutc_pkg::LRUTC_IN_DATA_W-1:0]  s_tdata,  // [31:0] key
	input  logic                                   s_tuser,  // [0] fill_allowed
	// result stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// [0] hit, [3:1] slot, [4] evicted, [36:5] evicted_key, [37] inserted,
	// [41:38] occupancy, [47:42] zero
	output logic [lrutc_pkg::LRUTC_OUT_DATA_W-1:0] m_tdata
);
	import lrutc_pkg::*;

	`include "lru_tag_cache_top_defines.svh"

	// Keys compare on their low KEY_BITS bits; the key field is only 32 wide.
	localparam int KW = (KEY_BITS < LRUTC_KEY_W) ? KEY_BITS : LRUTC_KEY_W;

	// input register
	logic                   valid_s1;
	logic [LRUTC_KEY_W-1:0] key_s1;
	logic                   fill_s1;

	// result register
	logic                   m_valid_q;
	lrutc_result_t          res_q;
	lrutc_result_t          res_d;

	logic                   adv;

	// Stage 1 retires its item whenever the result register is free or draining.
	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_s1  <= s_tdata[LRUTC_KEY_W-1:0];
			fill_s1 <= s_tuser;
		end
	end

	lrutc_store #(
		.CAPACITY (CAPACITY),
		.KW       (KW)
	) u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.key          (key_s1[KW-1:0]),
		.fill_allowed (fill_s1),
		.res          (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(LRUTC_OUT_DATA_W - 42)'(0), res_q.occupancy, res_q.inserted,
	                   res_q.evicted_key, res_q.evicted, res_q.slot, res_q.hit};

	// A hit never evicts or inserts.
	`LRUTC_ASSERT_IMP(a_hit_excl, m_valid_q && res_q.hit, !res_q.evicted && !res_q.inserted, "hit with eviction or insertion")
	// Eviction without refill leaves the store one short of full.
	`LRUTC_ASSERT_IMP(a_evict_occ, m_valid_q && res_q.evicted && !res_q.inserted, res_q.occupancy == LRUTC_OCC_W'(CAPACITY - 1), "occupancy wrong after eviction")
	// Input only stalls when stage 1 is blocked by an untaken result.
	`LRUTC_ASSERT_IMP(a_stall_cause, !s_tready, valid_s1 && m_valid_q && !m_tready, "input stalled without cause")
	// A processed item always shows up as a result next cycle.
	`LRUTC_ASSERT_NEXT(a_adv_result, adv, m_valid_q, "processed item produced no result")

endmodule

// ===== hw/rtl/lrutc_store.sv =====
// Entry store of the LRU tag cache: keys, valid bits, ages, fill count.
// Depends on lrutc_pkg. Looks up combinationally and updates its state on each step.
module lrutc_store #(
	parameter int CAPACITY = 8,
	parameter int KW       = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [KW-1:0]              key,
	input  logic                       fill_allowed,
	output lrutc_pkg::lrutc_result_t   res
);
	import lrutc_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int AGE_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [KW-1:0]    key_q   [CAPACITY];
	logic [AGE_W-1:0] age_q   [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0] cnt_q;

	logic [CAPACITY-1:0] hit_vec, old_vec, valid_mid, free_vec;
	logic                hit, full, evict, ins;
	logic [IDX_W-1:0]    hit_idx, free_idx;
	logic [AGE_W-1:0]    hit_age;
	logic [KW-1:0]       ev_key;
	logic [CNT_W-1:0]    cnt_d;

	// Parallel lookup; keys are unique among valid entries, so vectors are one-hot.
	always_comb begin
		hit_idx = '0;
		hit_age = '0;
		ev_key  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == key);
			// valid ages form 0..count-1, so the oldest of a full store is CAPACITY-1
			old_vec[i] = valid_q[i] && (age_q[i] == AGE_W'(CAPACITY - 1));
			if (hit_vec[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
				hit_age = hit_age | age_q[i];
			end
			if (old_vec[i]) begin
				ev_key = ev_key | key_q[i];
			end
		end
	end

	assign hit       = |hit_vec;
	assign full      = (cnt_q == CNT_W'(CAPACITY));
	assign evict     = !hit && full;
	assign valid_mid = evict ? (valid_q & ~old_vec) : valid_q;
	// lowest clear bit, zero when every entry is valid
	assign free_vec  = ~valid_mid & (valid_mid + CAPACITY'(1));
	assign ins       = !hit && fill_allowed && (|free_vec);

	always_comb begin
		free_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (free_vec[i]) begin
				free_idx = free_idx | IDX_W'(i);
			end
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (evict) begin
			cnt_d = cnt_d - CNT_W'(1);
		end
		if (ins) begin
			cnt_d = cnt_d + CNT_W'(1);
		end
	end

	always_comb begin
		res.hit         = hit;
		res.slot        = hit ? LRUTC_SLOT_W'(hit_idx) :
		                  (ins ? LRUTC_SLOT_W'(free_idx) : '0);
		res.evicted     = evict;
		res.evicted_key = evict ? LRUTC_KEY_W'(ev_key) : '0;
		res.inserted    = ins;
		res.occupancy   = LRUTC_OCC_W'(cnt_d);
	end

	// Keys carry no reset.
	always_ff @(posedge clk) begin
		if (step && ins) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (free_vec[i]) begin
					key_q[i] <= key;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				age_q[i] <= '0;
			end
		end else if (step) begin
			cnt_q <= cnt_d;
			for (int i = 0; i < CAPACITY; i++) begin
				if (hit) begin
					if (hit_vec[i]) begin
						age_q[i] <= '0;
					end else if (valid_q[i] && (age_q[i] < hit_age)) begin
						age_q[i] <= age_q[i] + AGE_W'(1);
					end
				end else begin
					if (evict && old_vec[i]) begin
						valid_q[i] <= 1'b0;
						age_q[i]   <= '0;
					end
					if (ins) begin
						if (free_vec[i]) begin
							valid_q[i] <= 1'b1;
							age_q[i]   <= '0;
						end else if (valid_mid[i]) begin
							age_q[i] <= age_q[i] + AGE_W'(1);
						end
					end
				end
			end
		end
	end

endmodule

// ===== test/lru_tag_cache_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lru_tag_cache_top: random request and result stalls,
// an LRU tag store predictor, and an in-order check of every result item.
// Depends on lrutc_pkg and the lru_tag_cache_top RTL.
module lru_tag_cache_top_tb;
	import lrutc_pkg::*;

	localparam int IDLE_PCT    = 35;    // chance per cycle that a side idles
	localparam int STALL_LIMIT = 2000;  // cycles with no item moving on either side
	localparam int RANDOM_REQS = 1800;
	localparam int POOL_SIZE   = 12;
	localparam int DRAIN_WAIT  = 8;     // pipeline is 2 deep; margin for stray results

	typedef struct {
		logic [LRUTC_KEY_W-1:0] key;
		logic                   fill;
		bit                     drain;  // hold this request until the store has answered all
	} request_t;

	typedef struct packed {
		logic                    hit;
		logic [LRUTC_SLOT_W-1:0] slot;
		logic                    evicted;
		logic [LRUTC_KEY_W-1:0]  evicted_key;
		logic                    inserted;
		logic [LRUTC_OCC_W-1:0]  occupancy;
	} lookup_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [LRUTC_IN_DATA_W-1:0]  s_tdata = '0;   // [31:0] key
	logic                        s_tuser = 1'b0; // [0] fill_allowed
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	// [0] hit, [3:1] slot, [4] evicted, [36:5] evicted_key, [37] inserted, [41:38] occupancy
	logic [LRUTC_OUT_DATA_W-1:0] m_tdata;

	request_t       request_q[$];
	lookup_result_t expected_lookups[$];
	int             results_pending = 0;  // expected_lookups size as of the last edge
	int             failures = 0;
	int             stall_cycles = 0;
	int unsigned    cycle_count = 0;
	logic           calm_stretch;

	// predicted store contents
	logic [LRUTC_KEY_W-1:0] line_key[LRUTC_CAPACITY];
	bit                     line_valid[LRUTC_CAPACITY];
	bit [2:0]               line_age[LRUTC_CAPACITY];
	int                     line_count = 0;

	lru_tag_cache_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	// no idling on either side in this window
	assign calm_stretch = (cycle_count >= 900) && (cycle_count < 1500);

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
		end
	end

	// One lookup against the predicted store; updates it and returns the result item.
	function automatic lookup_result_t lru_lookup(logic [LRUTC_KEY_W-1:0] key, logic fill);
		lookup_result_t res;
		int             hit_line;
		int             victim;
		int             free_line;
		bit [2:0]       hit_age;
		res = '0;
		hit_line = -1;
		victim = -1;
		free_line = -1;
		for (int i = 0; i < LRUTC_CAPACITY; i++)
			if (hit_line < 0 && line_valid[i] && line_key[i] == key)
				hit_line = i;
		if (hit_line >= 0) begin
			// younger lines age by one, hit line becomes newest
			hit_age = line_age[hit_line];
			for (int i = 0; i < LRUTC_CAPACITY; i++)
				if (line_valid[i] && line_age[i] < hit_age)
					line_age[i]++;
			line_age[hit_line] = '0;
			res.hit = 1'b1;
			res.slot = LRUTC_SLOT_W'(hit_line);
		end else begin
			// full store: drop the oldest line, even if the fill is refused
			if (line_count >= LRUTC_CAPACITY) begin
				for (int i = 0; i < LRUTC_CAPACITY; i++)
					if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim]))
						victim = i;
				if (victim >= 0) begin
					res.evicted = 1'b1;
					res.evicted_key = line_key[victim];
					line_valid[victim] = 1'b0;
					line_age[victim] = '0;
					line_count--;
				end
			end
			if (fill) begin
				for (int i = 0; i < LRUTC_CAPACITY; i++)
					if (free_line < 0 && !line_valid[i])
						free_line = i;
				if (free_line >= 0) begin
					for (int i = 0; i < LRUTC_CAPACITY; i++)
						if (line_valid[i])
							line_age[i]++;
					line_key[free_line] = key;
					line_valid[free_line] = 1'b1;
					line_age[free_line] = '0;
					line_count++;
					res.inserted = 1'b1;
					res.slot = LRUTC_SLOT_W'(free_line);
				end
			end
		end
		res.occupancy = LRUTC_OCC_W'(line_count);
		return res;
	endfunction

	task automatic log_failure(string what, bit have_want, lookup_result_t want,
	                           lookup_result_t got);
		failures++;
		if (failures <= 10) begin
			if (have_want)
				$display("%0t ns: mismatch in%s: expected hit=%0b slot=%0d ev=%0b ev_key=%h ins=%0b occ=%0d, got hit=%0b slot=%0d ev=%0b ev_key=%h ins=%0b occ=%0d",
					$realtime, what, want.hit, want.slot, want.evicted, want.evicted_key,
					want.inserted, want.occupancy, got.hit, got.slot, got.evicted,
					got.evicted_key, got.inserted, got.occupancy);
			else
				$display("%0t ns: %s: hit=%0b slot=%0d ev=%0b ev_key=%h ins=%0b occ=%0d",
					$realtime, what, got.hit, got.slot, got.evicted, got.evicted_key,
					got.inserted, got.occupancy);
		end
	endtask

	function automatic void add_request(logic [LRUTC_KEY_W-1:0] key, logic fill,
	                                    bit drain = 1'b0);
		request_t req;
		req.key = key;
		req.fill = fill;
		req.drain = drain;
		request_q.push_back(req);
	endfunction

	// Request driver: presents request_q in order, idles at random, holds a drain
	// request back until every earlier item has been answered.
	always @(posedge clk or negedge arst_n) begin
		logic     took;
		logic     present;
		request_t head;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			took = s_tvalid && s_tready;
			if (took)
				void'(request_q.pop_front());
			if (!s_tvalid || took) begin
				present = 1'b0;
				if (request_q.size() != 0) begin
					head = request_q[0];
					// results_pending is registered, so never release a drain right after an accept
					if (head.drain)
						present = !took && results_pending == 0;
					else
						present = calm_stretch || $urandom_range(0, 99) >= IDLE_PCT;
				end
				s_tvalid <= present;
				if (present) begin
					s_tdata <= head.key;
					s_tuser <= head.fill;
				end
			end
		end
	end

	// Monitor: checks each result against the oldest prediction, then predicts
	// the request taken at this edge. Also drives the result-side stalls.
	always @(posedge clk or negedge arst_n) begin
		lookup_result_t got;
		lookup_result_t want;
		string          bad;
		if (!arst_n) begin
			m_tready <= 1'b0;
			results_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.hit = m_tdata[0];
				got.slot = m_tdata[3:1];
				got.evicted = m_tdata[4];
				got.evicted_key = m_tdata[36:5];
				got.inserted = m_tdata[37];
				got.occupancy = m_tdata[41:38];
				if (expected_lookups.size() == 0) begin
					log_failure("result with nothing expected", 1'b0, '0, got);
				end else begin
					want = expected_lookups.pop_front();
					bad = "";
					if (got.hit !== want.hit) bad = {bad, " hit"};
					if (got.slot !== want.slot) bad = {bad, " slot"};
					if (got.evicted !== want.evicted) bad = {bad, " evicted"};
					if (got.evicted_key !== want.evicted_key) bad = {bad, " evicted_key"};
					if (got.inserted !== want.inserted) bad = {bad, " inserted"};
					if (got.occupancy !== want.occupancy) bad = {bad, " occupancy"};
					if (bad != "")
						log_failure(bad, 1'b1, want, got);
				end
			end
			if (s_tvalid && s_tready)
				expected_lookups.push_back(lru_lookup(s_tdata, s_tuser));
			m_tready <= calm_stretch || $urandom_range(0, 99) >= IDLE_PCT;
			results_pending <= expected_lookups.size();
		end
	end

	// Watchdog: nothing moving for too long means a hang.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [LRUTC_KEY_W-1:0] key_pool[POOL_SIZE];
		logic [LRUTC_KEY_W-1:0] k;
		int                     pick;

		// directed: empty store, fill to full, hits, evictions with and without fill
		add_request(32'h0000_0000, 1'b0);  // refused fill on an empty store
		add_request(32'h0000_0000, 1'b1);
		add_request(32'hFFFF_FFFF, 1'b1);
		add_request(32'h0000_0000, 1'b0);  // hit ignores fill_allowed
		add_request(32'h8000_0000, 1'b1);
		add_request(32'h5555_5555, 1'b1);
		add_request(32'hAAAA_AAAA, 1'b1);
		add_request(32'h0000_0001, 1'b1);
		add_request(32'h7FFF_FFFF, 1'b1);
		add_request(32'h1234_5678, 1'b1);  // store now full
		add_request(32'hFFFF_FFFF, 1'b1);  // hit on a full store, no eviction
		add_request(32'hDEAD_BEEF, 1'b0);  // miss on full store: evicts, inserts nothing
		add_request(32'hDEAD_BEEF, 1'b1);  // refills the freed line
		add_request(32'hCAFE_F00D, 1'b1);  // evict and insert in one request
		add_request(32'hCAFE_F00D, 1'b0);  // hit on the newest line
		add_request(32'h8000_0000, 1'b1);  // evicted earlier: miss on a full store, evicts and inserts
		add_request(32'h0000_0000, 1'b1);  // oldest line was evicted: miss
		add_request(32'hFFFF_FFFE, 1'b1);  // one bit off a stored key

		// random: mostly a small key pool so hits and evictions stay frequent
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n % 150 == 149)
				for (int j = 0; j < 3; j++)
					key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
			pick = $urandom_range(0, 99);
			k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			if (pick >= 70)
				k = $urandom;
			else if (pick >= 55)
				k = k ^ (32'h1 << $urandom_range(0, LRUTC_KEY_W - 1));
			add_request(k, $urandom_range(0, 99) < 80, n == 0 || n == 900);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (request_q.size() != 0 || s_tvalid || results_pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
		if (expected_lookups.size() != 0) begin
			failures += expected_lookups.size();
			$display("%0d result items never arrived", expected_lookups.size());
		end
		if (failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== lru_tag_cache_top.f =====
+incdir+hw/rtl
hw/rtl/lrutc_pkg.sv
hw/rtl/lrutc_store.sv
hw/rtl/lru_tag_cache_top.sv
test/lru_tag_cache_top_tb.sv
